### design/sft_pkg.sv
// shared types and constants for the serial frame transmitter
`default_nettype none

package sft_pkg;

   // command codes carried in the request beat
   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_TICK = 1'b1;

   // line levels and bit positions
   localparam logic       LEVEL_LOW  = 1'b0;
   localparam logic       LEVEL_HIGH = 1'b1;
   localparam logic [2:0] MSB_INDEX  = 3'd7;

   typedef struct packed {
      logic       command;
      logic [7:0] data_byte;
      logic       last_byte;
   } req_payload_type;

   typedef struct packed {
      logic line_level;
      logic frame_end;
   } rsp_payload_type;

   // strobes and write data from the sequencer to the message store
   typedef struct packed {
      logic       wr_en;
      logic       rd_en;
      logic [7:0] wr_data;
   } store_cmd_type;

endpackage

`default_nettype wire

### design/sft_store.sv
// message byte store: one write port, one registered read port
`default_nettype none

module sft_store
   import sft_pkg::*;
#(
   parameter int MAX_BYTES = 256,
   parameter int ADDR_W    = 8
) (
   input  wire logic              clock,
   input  wire store_cmd_type     store_cmd,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic [7:0]             rd_data
);

   logic [7:0] mem [MAX_BYTES];
   logic [7:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (store_cmd.wr_en) begin
         mem[wr_addr] <= store_cmd.wr_data;
      end
   end

   // read port, data held until the next read
   always_ff @(posedge clock) begin
      if (store_cmd.rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### design/sft_ctrl.sv
// frame sequencer: collects loads, walks the frame phases, drives result beats
`default_nettype none

module sft_ctrl
   import sft_pkg::*;
#(
   parameter int MAX_BYTES = 256,
   parameter int ADDR_W    = 8,
   parameter int CNT_W     = 9
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              accept,
   input  wire req_payload_type   req_payload,
   input  wire logic [7:0]        rd_data,
   output store_cmd_type          store_cmd,
   output logic [ADDR_W-1:0]      wr_addr,
   output logic [ADDR_W-1:0]      rd_addr,
   output logic                   rsp_strobe,
   output rsp_payload_type        rsp_payload
);

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_START,
      PH_SYNC,
      PH_WAIT,
      PH_SEND,
      PH_STOP,
      PH_FINISH
   } phase_type;

   localparam logic [CNT_W-1:0] MAX_COUNT = CNT_W'(MAX_BYTES);
   localparam logic [CNT_W-1:0] ONE_COUNT = CNT_W'(1);

   phase_type         phase_ff, phase_in;
   logic [CNT_W-1:0]  byte_count_ff, byte_count_in;
   logic [CNT_W-1:0]  bytes_sent_ff, bytes_sent_in;
   logic [2:0]        bit_index_ff, bit_index_in;
   logic              strobe_ff, strobe_in;
   rsp_payload_type   payload_ff, payload_in;
   logic [CNT_W-1:0]  read_index;
   logic              is_load, is_tick;

   assign is_load = accept && (req_payload.command == CMD_LOAD);
   assign is_tick = accept && (req_payload.command == CMD_TICK);

   // store addressing: next free slot, and the byte to send next (last loaded first)
   assign read_index = byte_count_ff - bytes_sent_ff - ONE_COUNT;
   assign wr_addr    = byte_count_ff[ADDR_W-1:0];
   assign rd_addr    = read_index[ADDR_W-1:0];

   // next state and result beat
   always_comb begin
      phase_in      = phase_ff;
      byte_count_in = byte_count_ff;
      bytes_sent_in = bytes_sent_ff;
      bit_index_in  = bit_index_ff;
      strobe_in     = 1'b0;
      payload_in    = '{line_level: LEVEL_HIGH, frame_end: 1'b0};
      store_cmd     = '{wr_en: 1'b0, rd_en: 1'b0, wr_data: req_payload.data_byte};

      if (is_load && (phase_ff == PH_IDLE)) begin
         if (byte_count_ff < MAX_COUNT) begin
            store_cmd.wr_en = 1'b1;
            byte_count_in   = byte_count_ff + ONE_COUNT;
         end
         if (req_payload.last_byte) begin
            phase_in = PH_START;
         end
      end else if (is_tick) begin
         case (phase_ff)
            PH_START: begin
               phase_in = PH_SYNC;
            end
            PH_SYNC: begin
               // fetch the byte now, it is ready for the first data bit
               store_cmd.rd_en       = 1'b1;
               phase_in              = PH_WAIT;
               strobe_in             = 1'b1;
               payload_in.line_level = LEVEL_LOW;
            end
            PH_WAIT: begin
               phase_in  = PH_SEND;
               strobe_in = 1'b1;
            end
            PH_SEND: begin
               strobe_in             = 1'b1;
               payload_in.line_level = rd_data[MSB_INDEX - bit_index_ff];
               bit_index_in          = bit_index_ff + 3'd1;
               if (bit_index_ff == MSB_INDEX) begin
                  bytes_sent_in = bytes_sent_ff + ONE_COUNT;
                  phase_in      = PH_STOP;
               end
            end
            PH_STOP: begin
               strobe_in = 1'b1;
               phase_in  = (bytes_sent_ff >= byte_count_ff) ? PH_FINISH : PH_SYNC;
            end
            PH_FINISH: begin
               strobe_in            = 1'b1;
               payload_in.frame_end = 1'b1;
               phase_in             = PH_IDLE;
               byte_count_in        = '0;
               bytes_sent_in        = '0;
               bit_index_in         = '0;
            end
            default: begin
               phase_in = PH_IDLE;
            end
         endcase
      end
   end

   // state and registered result beat
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_IDLE;
         byte_count_ff <= '0;
         bytes_sent_ff <= '0;
         bit_index_ff  <= '0;
         strobe_ff     <= 1'b0;
      end else begin
         phase_ff      <= phase_in;
         byte_count_ff <= byte_count_in;
         bytes_sent_ff <= bytes_sent_in;
         bit_index_ff  <= bit_index_in;
         strobe_ff     <= strobe_in;
      end
      payload_ff <= payload_in;
   end

   assign rsp_strobe  = strobe_ff;
   assign rsp_payload = payload_ff;

`ifndef SYNTHESIS
   // a result beat only follows an accepted tick
   a_strobe_from_tick: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(is_tick))
      else $error("result beat without a tick");

   // the end marker leaves the sequencer idle with counts cleared
   a_end_to_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_payload.frame_end) |-> (phase_ff == PH_IDLE && byte_count_ff == '0))
      else $error("frame end without return to idle");

   // data bits are only sent while a byte is left in the store
   a_send_has_byte: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_SEND) |-> (bytes_sent_ff < byte_count_ff))
      else $error("send phase with nothing left");

   // a partial byte only exists in the send phase
   a_bit_index_send: assert property (@(posedge clock) disable iff (reset)
      (bit_index_ff != 3'd0) |-> (phase_ff == PH_SEND))
      else $error("bit index left over outside send");
`endif

endmodule

`default_nettype wire

### design/serial_frame_transmitter_top.sv
// top level of the serial frame transmitter
//
// Request channel: a beat is taken on a rising edge with start high and
// busy low. busy stays low, so one beat is taken every cycle.
// A load beat (command 0) stores data_byte while idle and not full; the load
// with last_byte set starts a frame sequence. Loads outside idle are dropped.
// A tick beat (command 1) is one bit time: the first tick after the start
// drives nothing, then each byte goes out as 0, 1, eight data bits MSB
// first and a 1 stop bit, last loaded byte first; a final tick drives 1
// with frame_end set and returns to idle. Ticks while idle drive nothing.
// Result channel: rsp_strobe marks a beat in the cycle after the tick that
// caused it, for exactly one cycle; the receiver cannot stall it.
// Throughput is one beat per cycle; the result beat is registered. Each
// byte is read from the store during its sync tick, two ticks ahead of
// its first data bit.
// Reset (synchronous) returns to idle with an empty message; the store
// contents are not cleared and need no clearing pass.
`default_nettype none

module serial_frame_transmitter_top
   import sft_pkg::*;
#(
   parameter int MAX_BYTES = 256
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            start,
   output logic                 busy,
   input  wire req_payload_type req_payload,
   output logic                 rsp_strobe,
   output rsp_payload_type      rsp_payload
);

   localparam int ADDR_W = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;
   localparam int CNT_W  = $clog2(MAX_BYTES + 1) + 1;

   store_cmd_type     store_cmd;
   logic [ADDR_W-1:0] wr_addr;
   logic [ADDR_W-1:0] rd_addr;
   logic [7:0]        rd_data;
   logic              accept;

   // every beat is taken
   assign busy   = 1'b0;
   assign accept = start && !busy;

   sft_ctrl #(
      .MAX_BYTES (MAX_BYTES),
      .ADDR_W    (ADDR_W),
      .CNT_W     (CNT_W)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .req_payload (req_payload),
      .rd_data     (rd_data),
      .store_cmd   (store_cmd),
      .wr_addr     (wr_addr),
      .rd_addr     (rd_addr),
      .rsp_strobe  (rsp_strobe),
      .rsp_payload (rsp_payload)
   );

   sft_store #(
      .MAX_BYTES (MAX_BYTES),
      .ADDR_W    (ADDR_W)
   ) u_store (
      .clock     (clock),
      .store_cmd (store_cmd),
      .wr_addr   (wr_addr),
      .rd_addr   (rd_addr),
      .rd_data   (rd_data)
   );

endmodule

`default_nettype wire
